FILE: src/ptql_pkg.sv
// ---------------------------------------------------------------------------
// ptql_pkg
// Shared types and constants for the play-time quota limiter: profile
// entry layout, configuration register set, per-beat operation and result.
// ---------------------------------------------------------------------------
package ptql_pkg;

    // Field widths
    localparam int SLOT_W   = 3;
    localparam int TIME_W   = 32;
    localparam int REG_W    = 17;
    localparam int CAP_W    = 3;
    localparam int PCOUNT_W = 4;
    localparam int IDX_W    = 2;

    // Stream widths: input 72 bits exact, result 66 bits padded to 72
    localparam int IN_DATA_W  = 72;
    localparam int RES_W      = 66;
    localparam int OUT_DATA_W = 72;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_REST_SECONDS    = 2'd0;
    localparam logic [IDX_W-1:0] REG_DAILY_LIMIT     = 2'd1;
    localparam logic [IDX_W-1:0] REG_SESSION_LIMIT   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [REG_W-1:0] REST_SECONDS_RST    = 17'd900;
    localparam logic [REG_W-1:0] DAILY_LIMIT_RST     = 17'd3600;
    localparam logic [REG_W-1:0] SESSION_LIMIT_RST   = 17'd1800;

    // Command codes
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_RECHARGE = 1'b1;

    // Per-tick cap on counted seconds, and profile count that enables sessions
    localparam logic [TIME_W-1:0]   TICK_CAP     = 32'd5;
    localparam logic [PCOUNT_W-1:0] MIN_PROFILES = 4'd2;

    // One profile's stored state
    typedef struct packed {
        logic [TIME_W-1:0] last_played;
        logic [TIME_W-1:0] day_index;
        logic [TIME_W-1:0] day_count;
        logic [TIME_W-1:0] session_count;
        logic [TIME_W-1:0] rest_end;
    } entry_t;

    // Configuration register set
    typedef struct packed {
        logic [REG_W-1:0] rest_seconds;
        logic [REG_W-1:0] daily_limit;
        logic [REG_W-1:0] session_limit;
    } cfg_t;

    // Operation handed to the update stage, with precomputed terms
    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] day;
        logic [CAP_W-1:0]  add_cap;
        logic              multi;
        logic [TIME_W-1:0] rest_end_new;
    } op_t;

    // Result beat
    typedef struct packed {
        logic              stop_play;
        logic              resting_now;
        logic [TIME_W-1:0] session_used;
        logic [TIME_W-1:0] day_used;
    } result_t;

endpackage

FILE: src/play_time_quota_limiter_core.sv
// ---------------------------------------------------------------------------
// play_time_quota_limiter_core
// Per-profile play-time quota: day budget, session budget with forced rest,
// and recharge after a break. Profile state lives in one entry memory.
// ---------------------------------------------------------------------------
// Pipeline: a taken input beat passes stage 1 (memory read and day-index
//   multiply), stage 2 (update and write-back) and then the output register,
//   which drives m_tvalid with the result beat.
// Throughput: one beat per cycle unless m_tready stalls; back-to-back beats
//   on the same profile are served by forwarding the entry written in stage 2.
// Reset: synchronous, active low; clears the pipeline, restores the register
//   defaults and clears all per-entry valid bits together (no sweep).
module play_time_quota_limiter_core
    import ptql_pkg::*;
#(
    parameter int PROFILE_SLOTS = 8,
    parameter int DAY_LENGTH    = 86400
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [REG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // profile_slot[2:0], time_now[34:3], elapsed_seconds[66:35],
    // screen_idle[67], profile_count[71:68]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[0]
    input  logic                  s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // stop_play[0], resting_now[1], session_used[33:2], day_used[65:34], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW        = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
    // day = floor(now * DAY_RECIP / 2^DAY_SHIFT), exact for all 32-bit now
    localparam int DAY_SHIFT = TIME_W + $clog2(DAY_LENGTH);
    localparam int PROD_W    = DAY_SHIFT + TIME_W;
    localparam logic [33:0] DAY_RECIP =
        34'(((PROD_W'(1) << DAY_SHIFT) + PROD_W'(DAY_LENGTH) - PROD_W'(1)) /
            PROD_W'(DAY_LENGTH));
    localparam logic [31:0] SLOTS_U = 32'(PROFILE_SLOTS);

    // configuration
    cfg_t cfg_reg;

    // stage 1
    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [TIME_W-1:0]   s1_now_reg;
    logic [TIME_W-1:0]   s1_dt_reg;
    logic                s1_idle_reg;
    logic [PCOUNT_W-1:0] s1_pcount_reg;
    logic [AW-1:0]       s1_addr;

    // stage 2
    logic                s2_valid_reg;
    logic                s2_cmd_reg;
    logic [AW-1:0]       s2_addr_reg;
    logic                s2_in_range_reg;
    logic [TIME_W-1:0]   s2_now_reg;
    logic [CAP_W-1:0]    s2_cap_reg;
    logic                s2_multi_reg;
    logic [TIME_W-1:0]   s2_rest_end_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    entry_t              rd_data_reg;
    logic                rd_valid_reg;
    logic                fwd_sel_reg;
    entry_t              fwd_data_reg;

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             out_res_reg;

    // entry memory and per-entry valid bits
    entry_t              mem [PROFILE_SLOTS];
    logic [PROFILE_SLOTS-1:0] valid_reg;

    // datapath
    op_t                 op;
    entry_t              entry_cur;
    entry_t              upd_entry;
    result_t             upd_res;

    logic                accept;
    logic                adv1;
    logic                s2_move;
    logic                commit;

    // Flow control: each stage moves when the one after it frees up
    assign s2_move  = s2_valid_reg && (!out_valid_reg || m_tready);
    assign commit   = s2_move && s2_in_range_reg;
    assign adv1     = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign s_tready = aresetn && (!s1_valid_reg || adv1);
    assign accept   = s_tvalid && s_tready;
    assign s1_addr  = AW'(s1_slot_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rest_seconds  <= REST_SECONDS_RST;
            cfg_reg.daily_limit   <= DAILY_LIMIT_RST;
            cfg_reg.session_limit <= SESSION_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REST_SECONDS:  cfg_reg.rest_seconds  <= cfg_wdata;
                REG_DAILY_LIMIT:   cfg_reg.daily_limit   <= cfg_wdata;
                REG_SESSION_LIMIT: cfg_reg.session_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (adv1) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload: unpack the beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg    <= s_tuser;
            s1_slot_reg   <= s_tdata[2:0];
            s1_now_reg    <= s_tdata[34:3];
            s1_dt_reg     <= s_tdata[66:35];
            s1_idle_reg   <= s_tdata[67];
            s1_pcount_reg <= s_tdata[71:68];
        end
    end

    // Stage 2 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv1) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_move) begin
            s2_valid_reg <= 1'b0;
        end
    end

    // Stage 2 payload: precompute tick terms and the day-index product
    always_ff @(posedge aclk) begin
        if (adv1) begin
            s2_cmd_reg      <= s1_cmd_reg;
            s2_addr_reg     <= s1_addr;
            s2_in_range_reg <= 32'(s1_slot_reg) < SLOTS_U;
            s2_now_reg      <= s1_now_reg;
            s2_cap_reg      <= s1_idle_reg ? '0 :
                               (s1_dt_reg > TICK_CAP) ? CAP_W'(TICK_CAP) :
                               s1_dt_reg[CAP_W-1:0];
            s2_multi_reg    <= s1_pcount_reg >= MIN_PROFILES;
            s2_rest_end_reg <= s1_now_reg + TIME_W'(cfg_reg.rest_seconds);
            s2_prod_reg     <= PROD_W'(s1_now_reg) * PROD_W'(DAY_RECIP);
            rd_valid_reg    <= valid_reg[s1_addr];
            // same entry being written this edge: take the new value
            fwd_sel_reg     <= commit && (s2_addr_reg == s1_addr);
            fwd_data_reg    <= upd_entry;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (commit) begin
            mem[s2_addr_reg] <= upd_entry;
        end
        if (adv1) begin
            rd_data_reg <= mem[s1_addr];
        end
    end

    // Valid bits: an entry never written reads as all zeros
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (commit) begin
            valid_reg[s2_addr_reg] <= 1'b1;
        end
    end

    // Stage 2 operand selection
    always_comb begin
        entry_cur       = fwd_sel_reg ? fwd_data_reg :
                          (rd_valid_reg ? rd_data_reg : '0);
        op.cmd          = s2_cmd_reg;
        op.time_now     = s2_now_reg;
        op.day          = s2_prod_reg[DAY_SHIFT +: TIME_W];
        op.add_cap      = s2_cap_reg;
        op.multi        = s2_multi_reg;
        op.rest_end_new = s2_rest_end_reg;
    end

    ptql_update u_update (
        .op        (op),
        .cfg       (cfg_reg),
        .entry_in  (entry_cur),
        .entry_out (upd_entry),
        .res       (upd_res)
    );

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s2_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // out-of-range slot: all result fields zero
    always_ff @(posedge aclk) begin
        if (s2_move) begin
            out_res_reg <= s2_in_range_reg ? upd_res : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_res_reg.day_used, out_res_reg.session_used,
                                   out_res_reg.resting_now, out_res_reg.stop_play});

endmodule

FILE: src/ptql_update.sv
// ---------------------------------------------------------------------------
// ptql_update
// Modify step of the entry read-modify-write: applies a play tick or a
// recharge check to one profile entry and forms the result beat.
// ---------------------------------------------------------------------------
module ptql_update
    import ptql_pkg::*;
(
    input  op_t     op,
    input  cfg_t    cfg,
    input  entry_t  entry_in,
    output entry_t  entry_out,
    output result_t res
);

    logic              resting_old;
    logic [TIME_W-1:0] since_last;
    logic              break_ok;
    logic [TIME_W-1:0] add;
    logic [TIME_W-1:0] day_base;
    logic [TIME_W:0]   day_sum;
    logic [TIME_W-1:0] day_sat;
    logic [TIME_W:0]   sess_sum;
    logic [TIME_W-1:0] sess_sat;
    logic              day_hit;
    logic              sess_hit;
    logic              stop;

    // Shared terms
    always_comb begin
        resting_old = op.time_now < entry_in.rest_end;
        since_last  = op.time_now - entry_in.last_played;
        // long enough away, clock not set back, not resting
        break_ok    = !resting_old && (op.time_now >= entry_in.last_played) &&
                      (since_last >= TIME_W'(cfg.rest_seconds));
        add         = resting_old ? '0 : TIME_W'(op.add_cap);
        // new day starts the day budget over
        day_base    = (entry_in.day_index != op.day) ? '0 : entry_in.day_count;
        day_sum     = {1'b0, day_base} + {1'b0, add};
        day_sat     = day_sum[TIME_W] ? '1 : day_sum[TIME_W-1:0];
        sess_sum    = {1'b0, entry_in.session_count} + {1'b0, add};
        sess_sat    = sess_sum[TIME_W] ? '1 : sess_sum[TIME_W-1:0];
        day_hit     = day_sat >= TIME_W'(cfg.daily_limit);
        sess_hit    = sess_sat >= TIME_W'(cfg.session_limit);
    end

    // Entry update
    always_comb begin
        entry_out = entry_in;
        stop      = 1'b0;
        case (op.cmd)
            CMD_RECHARGE: begin
                if (break_ok) begin
                    entry_out.session_count = '0;
                end
            end
            CMD_TICK: begin
                entry_out.last_played = op.time_now;
                entry_out.day_index   = op.day;
                entry_out.day_count   = day_sat;
                if (day_hit) begin
                    entry_out.session_count = '0;
                    stop                    = 1'b1;
                end else if (op.multi) begin
                    if (sess_hit) begin
                        // session spent: force a rest
                        entry_out.rest_end      = op.rest_end_new;
                        entry_out.session_count = '0;
                        stop                    = 1'b1;
                    end else begin
                        entry_out.session_count = sess_sat;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result beat
    always_comb begin
        res.stop_play    = stop;
        res.resting_now  = op.time_now < entry_out.rest_end;
        res.session_used = entry_out.session_count;
        res.day_used     = entry_out.day_count;
    end

endmodule

FILE: src/ptql_check.sv
// ---------------------------------------------------------------------------
// ptql_check
// Port-level checks on the quota limiter's result stream, bound to the core.
// ---------------------------------------------------------------------------
module ptql_check
    import ptql_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // Stalled result beat stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Stalled result beat keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Any stop clears the session count
    a_stop_session: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[33:2] == 32'd0)
        else $error("stop_play with nonzero session_used");

    // Pad bits above the result fields stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:RES_W] == '0)
        else $error("nonzero pad bits in result beat");

endmodule

bind play_time_quota_limiter_core ptql_check u_ptql_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
